FILE: hdl/orot_pkg.sv
package orot_pkg;

  // World corner: signed Q13.4
  typedef logic signed [16:0] coord_t;
  // Axis, difference of two world corners: signed Q14.4
  typedef logic signed [17:0] axis_t;
  // Single corner-by-axis product: signed Q27.8
  typedef logic signed [34:0] prod_t;
  // Projection, sum of two products: signed Q28.8
  typedef logic signed [35:0] dot_t;

  localparam int unsigned NUM_COORDS = 8;
  localparam int unsigned NUM_CORNERS = 4;
  localparam int unsigned NUM_AXES = 4;

  typedef coord_t coords_t [NUM_COORDS];

  // Positions of the world corners in a corner set
  localparam logic [2:0] UR_X = 3'd0;
  localparam logic [2:0] UR_Y = 3'd1;
  localparam logic [2:0] UL_X = 3'd2;
  localparam logic [2:0] UL_Y = 3'd3;
  localparam logic [2:0] LR_X = 3'd4;
  localparam logic [2:0] LR_Y = 3'd5;
  localparam logic [2:0] LL_X = 3'd6;
  localparam logic [2:0] LL_Y = 3'd7;

  // Input mode codes
  localparam logic MODE_STORE = 1'b0;
  localparam logic MODE_TEST  = 1'b1;

  // Load enables for the two registered stages inside an axis unit
  typedef struct packed {
    logic dot_en;
    logic span_en;
  } axis_ctl_t;

  // Plain dot product of one corner with one axis
  function automatic dot_t dot2(coord_t px, coord_t py, axis_t ax, axis_t ay);
    prod_t mx;
    prod_t my;
    mx = $signed(px) * $signed(ax);
    my = $signed(py) * $signed(ay);
    return 36'(mx) + 36'(my);
  endfunction

endpackage

FILE: hdl/orot_axis_test.sv
module orot_axis_test
  import orot_pkg::*;
(
  input  logic      clk,
  input  axis_ctl_t ctl,
  input  axis_t     axis_x,
  input  axis_t     axis_y,
  input  coords_t   a_crd,
  input  coords_t   b_crd,
  output logic      overlap
);

  dot_t a_dot [NUM_CORNERS];
  dot_t b_dot [NUM_CORNERS];
  dot_t a_lo;
  dot_t a_hi;
  dot_t b_lo;
  dot_t b_hi;
  dot_t a_lo_next;
  dot_t a_hi_next;
  dot_t b_lo_next;
  dot_t b_hi_next;

  function automatic dot_t min2(dot_t x, dot_t y);
    return (x < y) ? x : y;
  endfunction

  function automatic dot_t max2(dot_t x, dot_t y);
    return (x > y) ? x : y;
  endfunction

  // Project every corner of both rectangles onto the axis
  always_ff @(posedge clk) begin
    if (ctl.dot_en) begin
      for (int k = 0; k < NUM_CORNERS; k++) begin
        a_dot[k] <= dot2(a_crd[2*k], a_crd[2*k+1], axis_x, axis_y);
        b_dot[k] <= dot2(b_crd[2*k], b_crd[2*k+1], axis_x, axis_y);
      end
    end
  end

  // Reduce the projections to an interval per rectangle
  always_comb begin
    a_lo_next = min2(min2(a_dot[0], a_dot[1]), min2(a_dot[2], a_dot[3]));
    a_hi_next = max2(max2(a_dot[0], a_dot[1]), max2(a_dot[2], a_dot[3]));
    b_lo_next = min2(min2(b_dot[0], b_dot[1]), min2(b_dot[2], b_dot[3]));
    b_hi_next = max2(max2(b_dot[0], b_dot[1]), max2(b_dot[2], b_dot[3]));
  end

  always_ff @(posedge clk) begin
    if (ctl.span_en) begin
      a_lo <= a_lo_next;
      a_hi <= a_hi_next;
      b_lo <= b_lo_next;
      b_hi <= b_hi_next;
    end
  end

  // Intervals overlap inclusively: touching is no gap
  assign overlap = (b_lo <= a_hi) && (b_hi >= a_lo);

endmodule

FILE: hdl/oriented_rect_overlap_test_core.sv
// Oriented rectangle overlap test, separating axes.
//
// Input channel: in_valid / in_stall with mode, position and four corner
// offsets, all signed Q12.4. A mode 0 item stores its world corners as
// rectangle A and gives no result. A mode 1 item is rectangle B; it is
// tested against the A stored by the latest earlier mode 0 item.
// Output channel: out_valid / out_stall with colliding, one per mode 1 item,
// in input order.
//
// Pipeline: input register, world corners, axes, projections, intervals,
// result register. One item is taken every cycle while in_stall is low; the
// six pipeline stages each hold while the stage after them is full and held.
// A stalled result holds on the port and the stages behind it keep filling
// until every stage is occupied; then in_stall rises.
//
// Reset clears every stage valid bit and sets the stored rectangle A to four
// corners at the origin.
module oriented_rect_overlap_test_core
  import orot_pkg::*;
(
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_stall,
  input  logic               mode,
  input  logic signed [15:0] pos_x,
  input  logic signed [15:0] pos_y,
  input  logic signed [15:0] upper_right_x,
  input  logic signed [15:0] upper_right_y,
  input  logic signed [15:0] upper_left_x,
  input  logic signed [15:0] upper_left_y,
  input  logic signed [15:0] lower_right_x,
  input  logic signed [15:0] lower_right_y,
  input  logic signed [15:0] lower_left_x,
  input  logic signed [15:0] lower_left_y,
  output logic               out_valid,
  input  logic               out_stall,
  output logic               colliding
);

  // Stage valid bits
  logic v1, v2, v3, v4, v5;
  logic rdy1, rdy2, rdy3, rdy4, rdy5, rdy_out;

  // Stage 1: input register
  logic               s1_mode;
  logic signed [15:0] s1_px, s1_py;
  logic signed [15:0] s1_off [NUM_COORDS];

  // Stage 2: world corners of B and a snapshot of A
  coords_t b_next;
  coords_t a_store;
  coords_t s2_a;
  coords_t s2_b;

  // Stage 3: axes plus both corner sets
  axis_t   s3_ax [NUM_AXES];
  axis_t   s3_ay [NUM_AXES];
  coords_t s3_a;
  coords_t s3_b;

  axis_ctl_t           axis_ctl;
  logic [NUM_AXES-1:0] overlap;
  logic                store_en;

  // Each stage loads when it is empty or its contents move on
  assign rdy_out = !out_valid || !out_stall;
  assign rdy5    = !v5 || rdy_out;
  assign rdy4    = !v4 || rdy5;
  assign rdy3    = !v3 || rdy4;
  assign rdy2    = !v2 || rdy3;
  assign rdy1    = !v1 || rdy2;
  assign in_stall = !rdy1;

  // A store item leaves stage 1 here and goes no further
  assign store_en = v1 && (s1_mode == MODE_STORE) && rdy2;

  // Advance the valid bits
  always_ff @(posedge clk) begin
    if (rst) begin
      v1        <= 1'b0;
      v2        <= 1'b0;
      v3        <= 1'b0;
      v4        <= 1'b0;
      v5        <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      if (rdy1)    v1        <= in_valid;
      if (rdy2)    v2        <= v1 && (s1_mode == MODE_TEST);
      if (rdy3)    v3        <= v2;
      if (rdy4)    v4        <= v3;
      if (rdy5)    v5        <= v4;
      if (rdy_out) out_valid <= v5;
    end
  end

  // Capture the input transfer
  always_ff @(posedge clk) begin
    if (rdy1) begin
      s1_mode   <= mode;
      s1_px     <= pos_x;
      s1_py     <= pos_y;
      s1_off[UR_X] <= upper_right_x;
      s1_off[UR_Y] <= upper_right_y;
      s1_off[UL_X] <= upper_left_x;
      s1_off[UL_Y] <= upper_left_y;
      s1_off[LR_X] <= lower_right_x;
      s1_off[LR_Y] <= lower_right_y;
      s1_off[LL_X] <= lower_left_x;
      s1_off[LL_Y] <= lower_left_y;
    end
  end

  // World corners: offset plus position
  always_comb begin
    for (int k = 0; k < NUM_CORNERS; k++) begin
      b_next[2*k]   = 17'(s1_off[2*k])   + 17'(s1_px);
      b_next[2*k+1] = 17'(s1_off[2*k+1]) + 17'(s1_py);
    end
  end

  // Hold rectangle A
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int k = 0; k < NUM_COORDS; k++) a_store[k] <= '0;
    end else if (store_en) begin
      a_store <= b_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rdy2) begin
      s2_a <= a_store;
      s2_b <= b_next;
    end
  end

  // Form the four test axes
  always_ff @(posedge clk) begin
    if (rdy3) begin
      s3_ax[0] <= 18'(s2_a[UR_X]) - 18'(s2_a[UL_X]);
      s3_ay[0] <= 18'(s2_a[UR_Y]) - 18'(s2_a[UL_Y]);
      s3_ax[1] <= 18'(s2_a[UR_X]) - 18'(s2_a[LR_X]);
      s3_ay[1] <= 18'(s2_a[UR_Y]) - 18'(s2_a[LR_Y]);
      s3_ax[2] <= 18'(s2_b[UL_X]) - 18'(s2_b[LL_X]);
      s3_ay[2] <= 18'(s2_b[UL_Y]) - 18'(s2_b[LL_Y]);
      s3_ax[3] <= 18'(s2_b[UL_X]) - 18'(s2_b[UR_X]);
      s3_ay[3] <= 18'(s2_b[UL_Y]) - 18'(s2_b[UR_Y]);
      s3_a     <= s2_a;
      s3_b     <= s2_b;
    end
  end

  // Stages 4 and 5 live in the axis units
  assign axis_ctl.dot_en  = rdy4;
  assign axis_ctl.span_en = rdy5;

  for (genvar g = 0; g < NUM_AXES; g++) begin : g_axis
    orot_axis_test u_axis (
      .clk     (clk),
      .ctl     (axis_ctl),
      .axis_x  (s3_ax[g]),
      .axis_y  (s3_ay[g]),
      .a_crd   (s3_a),
      .b_crd   (s3_b),
      .overlap (overlap[g])
    );
  end

  // Any separating axis clears the hit
  always_ff @(posedge clk) begin
    if (rdy_out) begin
      colliding <= &overlap;
    end
  end

endmodule

FILE: hdl/orot_checker.sv
module orot_checker (
  input logic clk,
  input logic rst,
  input logic in_valid,
  input logic in_stall,
  input logic out_valid,
  input logic out_stall,
  input logic colliding
);

  // No result right after reset
  a_reset_empty: assert property (@(posedge clk) rst |=> !out_valid)
    else $error("result valid after reset");

  // The input side backs up only behind a held result
  a_stall_cause: assert property (@(posedge clk) disable iff (rst)
    in_stall |-> (out_valid && out_stall))
    else $error("input stalled while the result side moves");

  // A held result stays on the port
  a_result_hold: assert property (@(posedge clk) disable iff (rst)
    (out_valid && out_stall) |=> (out_valid && $stable(colliding)))
    else $error("held result changed");

  // An idle input side with an empty result register never stalls
  a_idle_ready: assert property (@(posedge clk) disable iff (rst)
    !out_valid |-> !in_stall)
    else $error("input stalled with empty result register");

endmodule

bind oriented_rect_overlap_test_core orot_checker u_orot_checker (.*);

FILE: dv/tb_oriented_rect_overlap_test_core.sv
`timescale 1ns / 1ps
module tb_oriented_rect_overlap_test_core;
  import orot_pkg::*;

  localparam int RANDOM_ITEMS = 450;
  localparam int CYCLE_LIMIT  = 100000;
  localparam int DRAIN_CYCLES = 20;
  localparam int HOLD_AT      = 80;
  localparam int HOLD_CYCLES  = 60;

  typedef struct {
    logic               mode;
    logic signed [15:0] px;
    logic signed [15:0] py;
    logic signed [15:0] off [NUM_COORDS];
    bit                 fixed;
    bit                 want;
  } rect_item_t;

  logic               clk;
  logic               rst;
  logic               in_valid;
  logic               in_stall;
  logic               mode;
  logic signed [15:0] pos_x;
  logic signed [15:0] pos_y;
  logic signed [15:0] upper_right_x;
  logic signed [15:0] upper_right_y;
  logic signed [15:0] upper_left_x;
  logic signed [15:0] upper_left_y;
  logic signed [15:0] lower_right_x;
  logic signed [15:0] lower_right_y;
  logic signed [15:0] lower_left_x;
  logic signed [15:0] lower_left_y;
  logic               out_valid;
  logic               out_stall;
  logic               colliding;

  rect_item_t rect_items [$];
  bit         pending_hits [$];
  coords_t    stored_rect;
  int         errors = 0;
  int         cycles = 0;

  oriented_rect_overlap_test_core dut (.*);

  initial clk = 1'b0;
  always #6 clk = ~clk;

  initial begin
    rst = 1'b1;
    repeat (11) @(posedge clk);
    rst <= 1'b0;
  end

  // Abort a hung run
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles >= CYCLE_LIMIT) begin
      $display("SCOREBOARD MISMATCH");
      $finish;
    end
  end

  // Append a rectangle to the stimulus list
  function automatic void queue_rect(rect_item_t it);
    rect_items.insert(rect_items.size(), it);
  endfunction

  // Append an expected result to the scoreboard
  function automatic void queue_hit(bit hit);
    pending_hits.insert(pending_hits.size(), hit);
  endfunction

  // Offsets go in corner order: UR, UL, LR, LL, x before y
  function automatic rect_item_t make_rect(logic m, int px, int py,
                                           int urx, int ury, int ulx, int uly,
                                           int lrx, int lry, int llx, int lly,
                                           bit fixed = 1'b0, bit want = 1'b0);
    rect_item_t it;
    it.mode = m;
    it.px = 16'(px);
    it.py = 16'(py);
    it.off[UR_X] = 16'(urx);
    it.off[UR_Y] = 16'(ury);
    it.off[UL_X] = 16'(ulx);
    it.off[UL_Y] = 16'(uly);
    it.off[LR_X] = 16'(lrx);
    it.off[LR_Y] = 16'(lry);
    it.off[LL_X] = 16'(llx);
    it.off[LL_Y] = 16'(lly);
    it.fixed = fixed;
    it.want = want;
    return it;
  endfunction

  // Mostly true rotated rectangles near the origin, some raw noise and extremes
  function automatic rect_item_t random_rect();
    rect_item_t it;
    int kind, sel, a, b, p, q, ux, uy, vx, vy, k;
    logic signed [15:0] f;
    it.mode = ($urandom_range(0, 9) < 3) ? MODE_STORE : MODE_TEST;
    it.fixed = 1'b0;
    it.want = 1'b0;
    kind = $urandom_range(0, 9);
    if (kind < 7) begin
      a = int'($urandom_range(0, 8)) - 4;
      b = int'($urandom_range(0, 8)) - 4;
      p = $urandom_range(1, 24);
      q = $urandom_range(1, 24);
      ux = p * a;
      uy = p * b;
      vx = -q * b;
      vy = q * a;
      it.px = 16'(int'($urandom_range(0, 400)) - 200);
      it.py = 16'(int'($urandom_range(0, 400)) - 200);
      it.off[UR_X] = 16'(ux + vx);
      it.off[UR_Y] = 16'(uy + vy);
      it.off[UL_X] = 16'(-ux + vx);
      it.off[UL_Y] = 16'(-uy + vy);
      it.off[LR_X] = 16'(ux - vx);
      it.off[LR_Y] = 16'(uy - vy);
      it.off[LL_X] = 16'(-ux - vx);
      it.off[LL_Y] = 16'(-uy - vy);
    end else begin
      for (k = 0; k < NUM_COORDS + 2; k++) begin
        sel = (kind < 9) ? 3 : $urandom_range(0, 3);
        case (sel)
          0: f = 16'sh7fff;
          1: f = 16'sh8000;
          2: f = '0;
          default: f = 16'($urandom);
        endcase
        if (k < NUM_COORDS) it.off[k] = f;
        else if (k == NUM_COORDS) it.px = f;
        else it.py = f;
      end
    end
    return it;
  endfunction

  // Add the position to each corner offset
  function automatic coords_t world_corners(rect_item_t it);
    coords_t w;
    int k;
    for (k = 0; k < NUM_COORDS; k++)
      w[k] = coord_t'(it.off[k]) + ((k % 2 == 0) ? coord_t'(it.px) : coord_t'(it.py));
    return w;
  endfunction

  // Min and max corner projection of one rectangle on one axis
  function automatic void project_span(coords_t c, longint ax, longint ay,
                                       output longint lo, output longint hi);
    longint d;
    int k;
    for (k = 0; k < NUM_CORNERS; k++) begin
      d = longint'(c[2 * k]) * ax + longint'(c[2 * k + 1]) * ay;
      if (k == 0 || d < lo) lo = d;
      if (k == 0 || d > hi) hi = d;
    end
  endfunction

  // Separating-axis test of rectangle B against the stored A
  function automatic bit predict_collision(coords_t b);
    longint ax [NUM_AXES];
    longint ay [NUM_AXES];
    longint lo_a, hi_a, lo_b, hi_b;
    bit hit;
    int i;
    ax[0] = longint'(stored_rect[UR_X]) - longint'(stored_rect[UL_X]);
    ay[0] = longint'(stored_rect[UR_Y]) - longint'(stored_rect[UL_Y]);
    ax[1] = longint'(stored_rect[UR_X]) - longint'(stored_rect[LR_X]);
    ay[1] = longint'(stored_rect[UR_Y]) - longint'(stored_rect[LR_Y]);
    ax[2] = longint'(b[UL_X]) - longint'(b[LL_X]);
    ay[2] = longint'(b[UL_Y]) - longint'(b[LL_Y]);
    ax[3] = longint'(b[UL_X]) - longint'(b[UR_X]);
    ay[3] = longint'(b[UL_Y]) - longint'(b[UR_Y]);
    hit = 1'b1;
    for (i = 0; i < NUM_AXES; i++) begin
      project_span(stored_rect, ax[i], ay[i], lo_a, hi_a);
      project_span(b, ax[i], ay[i], lo_b, hi_b);
      // touching intervals still count as overlap
      if (!(lo_b <= hi_a && hi_b >= lo_a)) hit = 1'b0;
    end
    return hit;
  endfunction

  // Input side: directed table, then random rectangles
  initial begin
    int n, gap;
    rect_item_t it;
    coords_t w;

    in_valid <= 1'b0;
    mode <= MODE_STORE;
    pos_x <= '0;
    pos_y <= '0;
    upper_right_x <= '0;
    upper_right_y <= '0;
    upper_left_x <= '0;
    upper_left_y <= '0;
    lower_right_x <= '0;
    lower_right_y <= '0;
    lower_left_x <= '0;
    lower_left_y <= '0;
    foreach (stored_rect[k]) stored_rect[k] = '0;

    // test before any store: A and B both collapse to the origin
    queue_rect(make_rect(MODE_TEST, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 1'b1, 1'b1));
    // far square against the point A: gap on a B axis
    queue_rect(make_rect(MODE_TEST, 1600, 1600, 16, 16, -16, 16, 16, -16,
                         -16, -16, 1'b1, 1'b0));
    // A: square of side 2.0 at the origin
    queue_rect(make_rect(MODE_STORE, 0, 0, 16, 16, -16, 16, 16, -16, -16, -16));
    // edges touching, then one LSB apart
    queue_rect(make_rect(MODE_TEST, 32, 0, 16, 16, -16, 16, 16, -16, -16, -16,
                         1'b1, 1'b1));
    queue_rect(make_rect(MODE_TEST, 33, 0, 16, 16, -16, 16, 16, -16, -16, -16,
                         1'b1, 1'b0));
    queue_rect(make_rect(MODE_TEST, 20, 20, 16, 0, 0, 16, 0, -16, -16, 0));
    // point rectangles: zero-length B axes never separate
    queue_rect(make_rect(MODE_TEST, 5, -3, 0, 0, 0, 0, 0, 0, 0, 0, 1'b1, 1'b1));
    queue_rect(make_rect(MODE_TEST, 100, 0, 0, 0, 0, 0, 0, 0, 0, 0, 1'b1, 1'b0));
    // extremes: both rectangles collapse, every axis has zero length
    queue_rect(make_rect(MODE_STORE, 32767, 32767, 32767, 32767, 32767, 32767,
                         32767, 32767, 32767, 32767));
    queue_rect(make_rect(MODE_TEST, -32768, -32768, -32768, -32768, -32768, -32768,
                         -32768, -32768, -32768, -32768, 1'b1, 1'b1));
    queue_rect(make_rect(MODE_TEST, 0, 0, 32767, 32767, -32768, 32767, 32767,
                         -32768, -32768, -32768));
    queue_rect(make_rect(MODE_STORE, -32768, 32767, 32767, 32767, -32768, 32767,
                         32767, -32768, -32768, -32768));
    queue_rect(make_rect(MODE_TEST, 32767, -32768, 32767, 32767, -32768, 32767,
                         32767, -32768, -32768, -32768));
    queue_rect(make_rect(MODE_TEST, -32768, 32767, -32768, -32768, 32767, -32768,
                         -32768, 32767, 32767, 32767));
    queue_rect(make_rect(MODE_TEST, 0, 0, 16, 16, -16, 16, 16, -16, -16, -16));
    // rotated A, then B near it from several sides
    queue_rect(make_rect(MODE_STORE, 0, 0, 10, 55, -50, -25, 50, 25, -10, -55));
    queue_rect(make_rect(MODE_TEST, 60, 40, 16, 16, -16, 16, 16, -16, -16, -16));
    queue_rect(make_rect(MODE_TEST, -50, 45, 16, 16, -16, 16, 16, -16, -16, -16));
    queue_rect(make_rect(MODE_TEST, 70, 70, 16, 16, -16, 16, 16, -16, -16, -16));
    // non-rectangular corner sets
    queue_rect(make_rect(MODE_STORE, 12, -7, 90, 3, -40, 60, 5, -80, -70, -2));
    queue_rect(make_rect(MODE_TEST, -20, 10, 30, -60, 45, 20, -15, 35, 8, -9));
    queue_rect(make_rect(MODE_STORE, 32767, -32768, 0, 0, 0, 0, 0, 0, 0, 0));
    queue_rect(make_rect(MODE_TEST, -1, -1, -1, -1, -1, -1, -1, -1, -1, -1));
    for (n = 0; n < RANDOM_ITEMS; n++) queue_rect(random_rect());

    @(posedge clk);
    while (rst) @(posedge clk);

    for (n = 0; n < rect_items.size(); n++) begin
      it = rect_items[n];
      gap = ((n / 50) % 3 == 1) ? 0 : $urandom_range(0, 3);
      if (gap > 0) begin
        in_valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      in_valid <= 1'b1;
      mode <= it.mode;
      pos_x <= it.px;
      pos_y <= it.py;
      upper_right_x <= it.off[UR_X];
      upper_right_y <= it.off[UR_Y];
      upper_left_x <= it.off[UL_X];
      upper_left_y <= it.off[UL_Y];
      lower_right_x <= it.off[LR_X];
      lower_right_y <= it.off[LR_Y];
      lower_left_x <= it.off[LL_X];
      lower_left_y <= it.off[LL_Y];
      // hold the payload until the transfer
      @(posedge clk);
      while (in_stall) @(posedge clk);
      w = world_corners(it);
      if (it.mode == MODE_STORE) stored_rect = w;
      else queue_hit(it.fixed ? it.want : predict_collision(w));
    end
    in_valid <= 1'b0;

    // drain outstanding results, then let the pipeline settle
    while (pending_hits.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (errors == 0) $display("SCOREBOARD CLEAN");
    else $display("SCOREBOARD MISMATCH");
    $finish;
  end

  // Output side: random stalls, one long hold-off to back up the pipeline
  initial begin
    int n, got;
    bit want;
    out_stall <= 1'b0;
    got = 0;
    @(posedge clk);
    while (rst) @(posedge clk);
    forever begin
      if (got == HOLD_AT) n = HOLD_CYCLES;
      else if ((got / 40) % 3 == 2) n = 0;
      else n = $urandom_range(0, 3);
      if (n > 0) begin
        out_stall <= 1'b1;
        repeat (n) @(posedge clk);
        out_stall <= 1'b0;
      end
      @(posedge clk);
      while (!out_valid) @(posedge clk);
      got++;
      // compare against the oldest prediction
      if (pending_hits.size() == 0) begin
        errors++;
        $error("colliding: expected none, actual %0b", colliding);
      end else begin
        want = pending_hits.pop_front();
        if (colliding !== want) begin
          errors++;
          $error("colliding: expected %0b, actual %0b", want, colliding);
        end
      end
    end
  end

endmodule
